// ===== design/vt4x4_pkg.sv =====
// Package: shared widths, types, mode codes and register reset values for the 4x4 transform.
`timescale 1ns / 1ps

package vt4x4_pkg;

   // Fixed-point format and datapath widths
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int LANES      = 4;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_DATA_W = 2 * DATA_W;
   localparam int ACT_W      = 2;

   // Mode codes carried in the action field
   localparam logic [ACT_W-1:0] ACT_VECTOR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POINT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DIR    = 2'd2;

   // 1.0 in fixed point, rounding bias for the final shift
   localparam logic [DATA_W-1:0] ONE_FX     = DATA_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0]  ROUND_BIAS = SUM_W'(1) << (FRAC_BITS - 1);

   typedef logic [LANES-1:0][DATA_W-1:0] fx_quad_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [PAIR_W-1:0]     pair_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   // Stage load enables handed to each lane
   typedef struct packed {
      logic prod_load;
      logic pair_load;
   } lane_ctl_type;

   // Matrix register reset values: identity
   function automatic logic [CSR_DATA_W-1:0] reg_reset_value(input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] val;
      val = '0;
      if (idx[0] == 1'b0 && idx[CSR_IDX_W-1:1] == 2'd0) begin
         val[DATA_W-1:0] = ONE_FX;
      end else if (idx[0] == 1'b0 && idx[CSR_IDX_W-1:1] == 2'd1) begin
         val[CSR_DATA_W-1:DATA_W] = ONE_FX;
      end else if (idx[0] == 1'b1 && idx[CSR_IDX_W-1:1] == 2'd2) begin
         val[DATA_W-1:0] = ONE_FX;
      end else if (idx[0] == 1'b1 && idx[CSR_IDX_W-1:1] == 2'd3) begin
         val[CSR_DATA_W-1:DATA_W] = ONE_FX;
      end
      return val;
   endfunction

endpackage

// ===== design/vt4x4_if.sv =====
// Interfaces: request and response channels of the 4x4 transform.
`timescale 1ns / 1ps

interface vt4x4_req_if;
   logic                                valid;
   logic                                ready;
   logic [vt4x4_pkg::ACT_W-1:0]         action;
   logic signed [vt4x4_pkg::DATA_W-1:0] in_x;
   logic signed [vt4x4_pkg::DATA_W-1:0] in_y;
   logic signed [vt4x4_pkg::DATA_W-1:0] in_z;
   logic signed [vt4x4_pkg::DATA_W-1:0] in_w;

   modport source (output valid, action, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, action, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vt4x4_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vt4x4_pkg::DATA_W-1:0] out_x;
   logic signed [vt4x4_pkg::DATA_W-1:0] out_y;
   logic signed [vt4x4_pkg::DATA_W-1:0] out_z;
   logic signed [vt4x4_pkg::DATA_W-1:0] out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// ===== design/vt4x4_lane.sv =====
// Lane: one matrix row dotted with the vector, rounded and saturated.
`timescale 1ns / 1ps

module vt4x4_lane (
   input  logic                         clock,
   input  vt4x4_pkg::lane_ctl_type      ctl,
   input  vt4x4_pkg::fx_quad_type       row,
   input  vt4x4_pkg::fx_quad_type       vec,
   output logic [vt4x4_pkg::DATA_W-1:0] result
);

   vt4x4_pkg::prod_type prod_ff [vt4x4_pkg::LANES];
   vt4x4_pkg::prod_type prod_in [vt4x4_pkg::LANES];
   vt4x4_pkg::pair_type pair_ff [2];
   vt4x4_pkg::pair_type pair_in [2];
   vt4x4_pkg::sum_type  sum;
   vt4x4_pkg::sum_type  shifted;
   logic [vt4x4_pkg::SUM_W-vt4x4_pkg::DATA_W:0] upper;

   // Four signed 32x32 products, one per column
   always_comb begin
      for (int c = 0; c < vt4x4_pkg::LANES; c++) begin
         prod_in[c] = vt4x4_pkg::prod_type'(signed'(row[c]))
                    * vt4x4_pkg::prod_type'(signed'(vec[c]));
      end
   end

   // Pairwise partial sums
   always_comb begin
      pair_in[0] = vt4x4_pkg::pair_type'(prod_ff[0]) + vt4x4_pkg::pair_type'(prod_ff[1]);
      pair_in[1] = vt4x4_pkg::pair_type'(prod_ff[2]) + vt4x4_pkg::pair_type'(prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_load) begin
         for (int c = 0; c < vt4x4_pkg::LANES; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
      if (ctl.pair_load) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
   end

   // Final add with round-half-up bias, arithmetic shift, saturate to 32 bits
   always_comb begin
      sum = vt4x4_pkg::sum_type'(pair_ff[0]) + vt4x4_pkg::sum_type'(pair_ff[1])
          + vt4x4_pkg::sum_type'(vt4x4_pkg::ROUND_BIAS);
      shifted = sum >>> vt4x4_pkg::FRAC_BITS;
      upper   = shifted[vt4x4_pkg::SUM_W-1:vt4x4_pkg::DATA_W-1];
      if ((&upper) || !(|upper)) begin
         result = shifted[vt4x4_pkg::DATA_W-1:0];
      end else if (upper[vt4x4_pkg::SUM_W-vt4x4_pkg::DATA_W]) begin
         result = {1'b1, {(vt4x4_pkg::DATA_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(vt4x4_pkg::DATA_W-1){1'b1}}};
      end
   end

endmodule

// ===== design/vt4x4_merge.sv =====
// Merge stage: collects the four lane results into the response register.
`timescale 1ns / 1ps

module vt4x4_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_dir,
   input  vt4x4_pkg::fx_quad_type lane_res,
   output logic                   up_ready,
   vt4x4_rsp_if.source            rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   vt4x4_pkg::fx_quad_type data_ff;
   vt4x4_pkg::fx_quad_type data_in;

   // Register is free when empty or being drained this cycle
   assign up_ready = !valid_ff || rsp_ch.ready;
   assign valid_in = up_ready ? in_valid : valid_ff;

   // Direction mode drops the w row
   always_comb begin
      data_in = lane_res;
      if (in_dir) begin
         data_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.out_x = data_ff[0];
   assign rsp_ch.out_y = data_ff[1];
   assign rsp_ch.out_z = data_ff[2];
   assign rsp_ch.out_w = data_ff[3];

endmodule

// ===== design/vertex_transform_4x4_top.sv =====
// Top level: 4x4 fixed-point matrix times vector, four row lanes and a merge stage.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  req_ch   | in  | valid / ready       | action, in_x, in_y, in_z, in_w
//  rsp_ch   | out | valid / ready       | out_x, out_y, out_z, out_w
//  csr_*    | in  | csr_we, no stall    | csr_index (0..7), csr_data (64 bit)
//
//  One transaction per clock sustained while rsp_ch is ready; an accepted request
//  passes in order through the vector, product, pair-sum and output registers.
//  Stages advance independently, so bubbles are squeezed out while rsp_ch stalls
//  and a request is taken as long as any stage is empty.
//  Synchronous reset empties the pipe and loads the identity matrix.

module vertex_transform_4x4_top (
   input  logic                             clock,
   input  logic                             reset,
   vt4x4_req_if.sink                        req_ch,
   vt4x4_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  logic [vt4x4_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vt4x4_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [vt4x4_pkg::CSR_DATA_W-1:0] matrix_ff [vt4x4_pkg::NUM_REGS];

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s3_valid_ff, s3_valid_in;
   logic                   s1_dir_ff, s2_dir_ff, s3_dir_ff;
   logic                   s1_dir_in;
   vt4x4_pkg::fx_quad_type vec_ff;
   vt4x4_pkg::fx_quad_type vec_in;
   logic                   rdy1, rdy2, rdy3, rdy4;
   vt4x4_pkg::lane_ctl_type lane_ctl;
   vt4x4_pkg::fx_quad_type rows [vt4x4_pkg::LANES];
   vt4x4_pkg::fx_quad_type lane_res;

   // Matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vt4x4_pkg::NUM_REGS; i++) begin
            matrix_ff[i] <= vt4x4_pkg::reg_reset_value(vt4x4_pkg::CSR_IDX_W'(i));
         end
      end else if (csr_we) begin
         matrix_ff[csr_index] <= csr_data;
      end
   end

   // Split each row out of its two registers
   always_comb begin
      for (int r = 0; r < vt4x4_pkg::LANES; r++) begin
         rows[r][0] = matrix_ff[2*r][vt4x4_pkg::DATA_W-1:0];
         rows[r][1] = matrix_ff[2*r][vt4x4_pkg::CSR_DATA_W-1:vt4x4_pkg::DATA_W];
         rows[r][2] = matrix_ff[2*r+1][vt4x4_pkg::DATA_W-1:0];
         rows[r][3] = matrix_ff[2*r+1][vt4x4_pkg::CSR_DATA_W-1:vt4x4_pkg::DATA_W];
      end
   end

   // Per-stage ready chain
   always_comb begin
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
      s1_valid_in = rdy1 ? req_ch.valid : s1_valid_ff;
      s2_valid_in = rdy2 ? s1_valid_ff  : s2_valid_ff;
      s3_valid_in = rdy3 ? s2_valid_ff  : s3_valid_ff;
      lane_ctl.prod_load = rdy2;
      lane_ctl.pair_load = rdy3;
   end

   assign req_ch.ready = rdy1;

   // Effective vector: point mode forces w = 1.0, direction mode drops w
   always_comb begin
      vec_in[0] = req_ch.in_x;
      vec_in[1] = req_ch.in_y;
      vec_in[2] = req_ch.in_z;
      case (req_ch.action)
         vt4x4_pkg::ACT_POINT: vec_in[3] = vt4x4_pkg::ONE_FX;
         vt4x4_pkg::ACT_DIR:   vec_in[3] = '0;
         default:              vec_in[3] = req_ch.in_w;
      endcase
      s1_dir_in = (req_ch.action == vt4x4_pkg::ACT_DIR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         vec_ff    <= vec_in;
         s1_dir_ff <= s1_dir_in;
      end
      if (rdy2) begin
         s2_dir_ff <= s1_dir_ff;
      end
      if (rdy3) begin
         s3_dir_ff <= s2_dir_ff;
      end
   end

   // One lane per matrix row
   for (genvar r = 0; r < vt4x4_pkg::LANES; r++) begin : g_lane
      vt4x4_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .row    (rows[r]),
         .vec    (vec_ff),
         .result (lane_res[r])
      );
   end

   vt4x4_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_valid_ff),
      .in_dir   (s3_dir_ff),
      .lane_res (lane_res),
      .up_ready (rdy4),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== design/vt4x4_check.sv =====
// Checker: port-level properties of the transform, bound to the top level.
`timescale 1ns / 1ps

module vt4x4_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [vt4x4_pkg::DATA_W-1:0]  rsp_out_x,
   input logic [vt4x4_pkg::DATA_W-1:0]  rsp_out_w
);

   // Transactions in flight: accepted but not yet delivered
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_fire && !rsp_fire) begin
         count_in = count_ff + 3'd1;
      end else if (!req_fire && rsp_fire) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_w))
      else $error("stalled response changed");

   // Never more than the four pipeline slots in flight
   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("more transactions in flight than pipeline slots");

   // Any empty slot means a request can be taken
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      count_ff < 3'd4 |-> req_ready)
      else $error("request stalled with room in the pipeline");

   // No response without an accepted request behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("response without a pending request");

endmodule

bind vertex_transform_4x4_top vt4x4_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_out_x (rsp_ch.out_x),
   .rsp_out_w (rsp_ch.out_w)
);
